// ===== rtl/core/hcp2u8_pkg.sv =====
package hcp2u8_pkg;

   localparam int NUM_CHARS = 8;
   localparam int NUM_PAIRS = 4;
   localparam int MAX_BYTES = 6;

   localparam logic [3:0] MAX_LEN = 4'd8;
   localparam logic [2:0] MIN_BC  = 3'd1;
   localparam logic [2:0] MAX_BC  = 3'd4;

   localparam logic [1:0] CONT_MARK  = 2'b10;
   localparam logic [2:0] LEAD2_MARK = 3'b110;
   localparam logic [3:0] LEAD3_MARK = 4'b1110;
   localparam logic [4:0] LEAD4_MARK = 5'b11110;
   localparam logic [5:0] LEAD5_MARK = 6'b111110;
   localparam logic [6:0] LEAD6_MARK = 7'b1111110;

   typedef enum logic [2:0] {
      ERR_NONE   = 3'd0,
      ERR_FIRST  = 3'd1,
      ERR_SECOND = 3'd2,
      ERR_COUNT  = 3'd3,
      ERR_LARGE  = 3'd4
   } err_type;

   typedef struct packed {
      logic [7:0] hex_char_0;
      logic [7:0] hex_char_1;
      logic [7:0] hex_char_2;
      logic [7:0] hex_char_3;
      logic [7:0] hex_char_4;
      logic [7:0] hex_char_5;
      logic [7:0] hex_char_6;
      logic [7:0] hex_char_7;
      logic [3:0] char_count;
      logic [2:0] byte_count;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
      logic [2:0] error;
   } rsp_type;

   // decoded characters: nybble and digit-valid flag per position
   typedef struct packed {
      logic [NUM_CHARS-1:0][3:0] nyb;
      logic [NUM_CHARS-1:0]      ok;
      logic [3:0]                len;
      logic [2:0]                bc;
   } dec_type;

   typedef struct packed {
      logic [31:0] value;
      err_type     err;
   } val_type;

   typedef struct packed {
      logic [MAX_BYTES-1:0][7:0] bytes;
      logic [2:0]                cnt;
      err_type                   err;
   } enc_type;

   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] r;
      r = '0;
      if (c inside {["0":"9"]}) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c inside {["a":"f"]}) begin
         r = {1'b1, 4'(c - 8'h57)};
      end else if (c inside {["A":"F"]}) begin
         r = {1'b1, 4'(c - 8'h37)};
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/hcp2u8_decode.sv =====
module hcp2u8_decode import hcp2u8_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    hold,
   input  logic    in_valid,
   input  req_type in_data,
   output logic    out_valid,
   output dec_type out_data
);

   logic          valid_ff;
   dec_type       data_ff;
   dec_type       data_in;
   logic [7:0]    ch [NUM_CHARS];
   logic [3:0]    len_clamp;
   logic [4:0]    dig;

   assign ch[0] = in_data.hex_char_0;
   assign ch[1] = in_data.hex_char_1;
   assign ch[2] = in_data.hex_char_2;
   assign ch[3] = in_data.hex_char_3;
   assign ch[4] = in_data.hex_char_4;
   assign ch[5] = in_data.hex_char_5;
   assign ch[6] = in_data.hex_char_6;
   assign ch[7] = in_data.hex_char_7;

   assign len_clamp = (in_data.char_count > MAX_LEN) ? MAX_LEN : in_data.char_count;

   always_comb begin
      data_in     = '0;
      data_in.bc  = in_data.byte_count;
      data_in.len = len_clamp;
      dig         = '0;
      // a NUL inside the counted span ends the string; scan down so the lowest wins
      for (int i = NUM_CHARS - 1; i >= 0; i--) begin
         if (4'(i) < len_clamp && ch[i] == 8'h00) begin
            data_in.len = 4'(i);
         end
      end
      for (int i = 0; i < NUM_CHARS; i++) begin
         dig             = hex_digit(ch[i]);
         data_in.ok[i]   = dig[4];
         data_in.nyb[i]  = dig[3:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!hold) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!hold) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== rtl/core/hcp2u8_parse.sv =====
module hcp2u8_parse import hcp2u8_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    hold,
   input  logic    in_valid,
   input  dec_type in_data,
   output logic    out_valid,
   output val_type out_data
);

   logic       valid_ff;
   val_type    data_ff;
   val_type    data_in;
   logic       done;
   logic [2:0] nbytes;

   assign nbytes = in_data.len[3:1];

   always_comb begin
      data_in = '0;
      done    = 1'b0;
      // first bad pair in order decides the code
      for (int p = 0; p < NUM_PAIRS; p++) begin
         if (!done && 4'(2 * p) < in_data.len) begin
            if (!in_data.ok[2 * p]) begin
               data_in.err = ERR_FIRST;
               done        = 1'b1;
            end else if (4'(2 * p + 1) >= in_data.len) begin
               data_in.err = ERR_SECOND;
               done        = 1'b1;
            end else if (!in_data.ok[2 * p + 1]) begin
               data_in.err = ERR_SECOND;
               done        = 1'b1;
            end
         end
      end
      for (int p = 0; p < NUM_PAIRS; p++) begin
         if (4'(2 * p + 2) <= in_data.len) begin
            data_in.value = {data_in.value[23:0], in_data.nyb[2 * p], in_data.nyb[2 * p + 1]};
         end
      end
      if (!done) begin
         if (in_data.bc < MIN_BC || in_data.bc > MAX_BC || nbytes != in_data.bc) begin
            data_in.err = ERR_COUNT;
         end else if (data_in.value[31]) begin
            data_in.err = ERR_LARGE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!hold) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!hold) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== rtl/core/hcp2u8_encode.sv =====
module hcp2u8_encode import hcp2u8_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    hold,
   input  logic    in_valid,
   input  val_type in_data,
   output logic    out_valid,
   output enc_type out_data
);

   logic       valid_ff;
   enc_type    data_ff;
   enc_type    data_in;
   logic [31:0] v;
   logic [5:0] grp [MAX_BYTES-1];
   logic [2:0] n;
   logic [2:0] gi;

   assign v = in_data.value;

   always_comb begin
      for (int j = 0; j < MAX_BYTES - 1; j++) begin
         grp[j] = v[6 * j +: 6];
      end
   end

   always_comb begin
      if (v[30:26] != '0) begin
         n = 3'd6;
      end else if (v[25:21] != '0) begin
         n = 3'd5;
      end else if (v[20:16] != '0) begin
         n = 3'd4;
      end else if (v[15:11] != '0) begin
         n = 3'd3;
      end else if (v[10:7] != '0) begin
         n = 3'd2;
      end else begin
         n = 3'd1;
      end
   end

   always_comb begin
      data_in     = '0;
      data_in.err = in_data.err;
      gi          = '0;
      if (in_data.err != ERR_NONE) begin
         data_in.cnt = 3'd1;
      end else begin
         data_in.cnt = n;
         case (n)
            3'd1: data_in.bytes[0] = {1'b0, v[6:0]};
            3'd2: data_in.bytes[0] = {LEAD2_MARK, v[10:6]};
            3'd3: data_in.bytes[0] = {LEAD3_MARK, v[15:12]};
            3'd4: data_in.bytes[0] = {LEAD4_MARK, v[20:18]};
            3'd5: data_in.bytes[0] = {LEAD5_MARK, v[25:24]};
            3'd6: data_in.bytes[0] = {LEAD6_MARK, v[30]};
            default: data_in.bytes[0] = '0;
         endcase
         // continuation bytes carry six bits each, high group first
         for (int k = 1; k < MAX_BYTES; k++) begin
            if (3'(k) < n) begin
               gi                  = n - 3'd1 - 3'(k);
               data_in.bytes[k]    = {CONT_MARK, grp[gi]};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!hold) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!hold) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== rtl/core/hcp2u8_serial.sv =====
module hcp2u8_serial import hcp2u8_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  enc_type in_data,
   output logic    hold,
   output logic    out_valid,
   output rsp_type out_data
);

   logic       valid_ff;
   enc_type    data_ff;
   logic [2:0] idx_ff;
   logic [2:0] idx_in;
   logic       at_last;

   assign at_last = (idx_ff == data_ff.cnt - 3'd1);
   // keep the current item until its final beat goes out
   assign hold    = valid_ff && !at_last;
   assign idx_in  = hold ? idx_ff + 3'd1 : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         idx_ff <= idx_in;
         if (!hold) begin
            valid_ff <= in_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!hold) begin
         data_ff <= in_data;
      end
   end

   assign out_valid         = valid_ff;
   assign out_data.out_byte = data_ff.bytes[idx_ff];
   assign out_data.last     = at_last;
   assign out_data.error    = data_ff.err;

endmodule

// ===== rtl/core/hex_codepoint_to_utf8_unit.sv =====
// The first byte reaches rsp_data through the decode, parse, encode and
// serializer registers. Each code point gives 1 to 6 UTF-8 bytes (1 on error),
// sent a byte a cycle; busy is high while all stages are full and bytes remain.
// The receiver cannot stall: every rsp_strobe beat is taken as it comes.
// Reset is synchronous; it clears all valid bits and the serializer byte index.
module hex_codepoint_to_utf8_unit import hcp2u8_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   logic    dec_valid;
   logic    val_valid;
   logic    enc_valid;
   dec_type dec_data;
   val_type val_data;
   enc_type enc_data;
   logic    ser_hold;
   logic    enc_hold;
   logic    val_hold;
   logic    dec_hold;

   // a stage holds only when it is full and the one below holds too
   assign enc_hold = enc_valid && ser_hold;
   assign val_hold = val_valid && enc_hold;
   assign dec_hold = dec_valid && val_hold;
   assign busy     = dec_hold;

   hcp2u8_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .hold      (dec_hold),
      .in_valid  (start),
      .in_data   (req_data),
      .out_valid (dec_valid),
      .out_data  (dec_data)
   );

   hcp2u8_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .hold      (val_hold),
      .in_valid  (dec_valid),
      .in_data   (dec_data),
      .out_valid (val_valid),
      .out_data  (val_data)
   );

   hcp2u8_encode u_encode (
      .clock     (clock),
      .reset     (reset),
      .hold      (enc_hold),
      .in_valid  (val_valid),
      .in_data   (val_data),
      .out_valid (enc_valid),
      .out_data  (enc_data)
   );

   hcp2u8_serial u_serial (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (enc_valid),
      .in_data   (enc_data),
      .hold      (ser_hold),
      .out_valid (rsp_strobe),
      .out_data  (rsp_data)
   );

   a_busy_needs_output: assert property (@(posedge clock) disable iff (reset)
      !rsp_strobe |-> !busy)
      else $error("busy while serializer is empty");

   a_bytes_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.last |=> rsp_strobe)
      else $error("gap inside a multi-byte sequence");

   a_error_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.error != ERR_NONE |-> rsp_data.last && rsp_data.out_byte == 8'h00)
      else $error("error beat not a single zero byte");

endmodule
